// File: rtl/core/ptt_pkg.sv
// ptt_pkg: shared types, codes and constants for the pan/tilt target tracker
// used by ptt_div, pan_tilt_target_tracker and ptt_checker; depends on nothing
package ptt_pkg;

    localparam int DATA_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int WAIT_W    = 4;

    // axis direction signs, each -1, 0 or 1
    localparam int PAN_SIGN  = 1;
    localparam int TILT_SIGN = 1;

    localparam logic [DATA_W-1:0] DRIVE_STOP       = 8'd127;
    localparam logic [DATA_W-1:0] TILT_CENTER      = 8'd127;
    localparam int                TILT_SEARCH_STEP = 10;
    localparam int                SEARCH_PERIOD    = 12;

    localparam logic [1:0] STATUS_OFF_CENTER = 2'd0;
    localparam logic [1:0] STATUS_AIMED      = 2'd1;
    localparam logic [1:0] STATUS_SEARCH     = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAN_TARGET  = 3'd0,
        CFG_TILT_TARGET = 3'd1,
        CFG_PAN_BAND    = 3'd2,
        CFG_TILT_BAND   = 3'd3,
        CFG_PAN_DIV     = 3'd4,
        CFG_TILT_DIV    = 3'd5,
        CFG_TILT_MIN    = 3'd6,
        CFG_TILT_MAX    = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PAN_START,
        S_PAN_WAIT,
        S_TILT_START,
        S_TILT_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    // signed step scaled by an axis sign of -1, 0 or 1
    function automatic logic signed [9:0] apply_sign(input int sgn,
                                                     input logic signed [9:0] st);
        logic signed [9:0] res;
        if (sgn > 0) begin
            res = st;
        end else if (sgn < 0) begin
            res = -st;
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/pan_tilt_target_tracker.sv
// pan_tilt_target_tracker: top level, sequencer and per-axis datapath
// depends on ptt_pkg and instantiates the shared divider ptt_div
//
// One beat in carries a camera centroid; one beat out carries the pan drive, the tilt
// position, an updated flag and a status code. A packet with target_y of zero (no lock)
// steps the search pacing. A locked packet passes the pan error and then the tilt error
// through one shared 8-step serial divider, each division made of a start, the shift
// steps and a write-back, and the sequencer waits for each division, so the divider sets
// the rate. The input stalls while a packet is in work; a finished result sits in an
// output register, and a new packet is taken while it waits to be read. A packet that
// finishes while the previous result is still held waits in the finish state until that
// result is read.
module pan_tilt_target_tracker #(
    parameter int                PAN_SIGN         = ptt_pkg::PAN_SIGN,
    parameter int                TILT_SIGN        = ptt_pkg::TILT_SIGN,
    parameter logic [7:0]        TILT_CENTER      = ptt_pkg::TILT_CENTER,
    parameter int                TILT_SEARCH_STEP = ptt_pkg::TILT_SEARCH_STEP,
    parameter int                SEARCH_PERIOD    = ptt_pkg::SEARCH_PERIOD
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [7:0]                      i_target_x,
    input  logic [7:0]                      i_target_y,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_pan_drive,
    output logic [7:0]                      o_tilt_position,
    output logic                            o_drive_updated,
    output logic [1:0]                      o_status,
    input  logic                            i_cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ptt_pkg::DATA_W-1:0]      i_cfg_data
);

    localparam int W = ptt_pkg::DATA_W;

    ptt_pkg::t_state r_state;
    ptt_pkg::t_state n_state;

    // configuration
    logic [W-1:0] r_pan_target;
    logic [W-1:0] r_tilt_target;
    logic [W-1:0] r_pan_band;
    logic [W-1:0] r_tilt_band;
    logic [W-1:0] r_pan_div;
    logic [W-1:0] r_tilt_div;
    logic [W-1:0] r_tilt_min;
    logic [W-1:0] r_tilt_max;

    // tracker state
    logic [W-1:0]               r_pan;
    logic [W-1:0]               r_tilt;
    logic [ptt_pkg::WAIT_W-1:0] r_wait;
    logic                       r_fresh;

    // packet in work
    logic [W-1:0] r_tx;
    logic [W-1:0] r_ty;
    logic         r_upd;
    logic [1:0]   r_status;
    logic         r_outside;
    logic         r_neg;

    // output register
    logic         r_o_valid;
    logic [W-1:0] r_o_pan;
    logic [W-1:0] r_o_tilt;
    logic         r_o_upd;
    logic [1:0]   r_o_status;

    ptt_pkg::t_div_req w_req;
    ptt_pkg::t_div_rsp w_rsp;

    logic w_accept;
    logic w_out_free;
    logic w_load_out;

    ptt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_load_out = (r_state == ptt_pkg::S_FINISH) && w_out_free;

    // axis error for the axis being started
    logic             w_tilt_axis;
    logic [W-1:0]     w_coord;
    logic [W-1:0]     w_target;
    logic [W-1:0]     w_band;
    logic [W-1:0]     w_gain;
    logic [W:0]       w_err;
    logic [W-1:0]     w_mag;

    assign w_tilt_axis = (r_state == ptt_pkg::S_TILT_START);
    assign w_coord     = w_tilt_axis ? r_ty : r_tx;
    assign w_target    = w_tilt_axis ? r_tilt_target : r_pan_target;
    assign w_band      = w_tilt_axis ? r_tilt_band : r_pan_band;
    assign w_gain      = w_tilt_axis ? r_tilt_div : r_pan_div;
    assign w_err       = {1'b0, w_coord} - {1'b0, w_target};
    assign w_mag       = w_err[W] ? W'(-w_err) : w_err[W-1:0];

    // step from the quotient
    logic [W-1:0]       w_qmag;
    logic signed [9:0]  w_step;
    logic signed [9:0]  w_pan_s;
    logic signed [9:0]  w_tilt_s;
    logic signed [10:0] w_pan_v;
    logic signed [10:0] w_tilt_v;
    logic [W-1:0]       w_pan_sat;
    logic [W-1:0]       w_tilt_clamp;

    assign w_qmag   = (w_rsp.quotient == '0) ? W'(1) : w_rsp.quotient;
    assign w_step   = !r_outside ? 10'sd0 :
                      r_neg ? -$signed({2'b00, w_qmag}) : $signed({2'b00, w_qmag});
    assign w_pan_s  = ptt_pkg::apply_sign(PAN_SIGN, w_step);
    assign w_tilt_s = ptt_pkg::apply_sign(TILT_SIGN, w_step);
    assign w_pan_v  = $signed({3'b000, ptt_pkg::DRIVE_STOP}) + 11'(w_pan_s);
    assign w_tilt_v = $signed({3'b000, r_tilt}) + 11'(w_tilt_s);

    always_comb begin
        priority if (w_pan_v < 11'sd0) begin
            w_pan_sat = '0;
        end else if (w_pan_v > 11'sd255) begin
            w_pan_sat = '1;
        end else begin
            w_pan_sat = w_pan_v[W-1:0];
        end
    end

    always_comb begin
        priority if (w_tilt_v < $signed({3'b000, r_tilt_min})) begin
            w_tilt_clamp = r_tilt_min;
        end else if (w_tilt_v > $signed({3'b000, r_tilt_max})) begin
            w_tilt_clamp = r_tilt_max;
        end else begin
            w_tilt_clamp = w_tilt_v[W-1:0];
        end
    end

    // search pacing
    logic [ptt_pkg::WAIT_W:0] w_cnt;
    logic                     w_search_step;
    logic [W:0]               w_sweep;
    logic [W-1:0]             w_sweep_tilt;

    assign w_cnt         = {1'b0, r_wait} + 1'b1;
    assign w_search_step = w_cnt > (ptt_pkg::WAIT_W + 1)'(SEARCH_PERIOD);
    assign w_sweep       = {1'b0, r_tilt} + (W + 1)'(TILT_SEARCH_STEP);

    always_comb begin
        priority if (r_tilt >= r_tilt_max) begin
            w_sweep_tilt = r_tilt_min;
        end else if (w_sweep >= {1'b0, r_tilt_max}) begin
            w_sweep_tilt = r_tilt_max;
        end else begin
            w_sweep_tilt = w_sweep[W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptt_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_target_y == '0) ? ptt_pkg::S_SEARCH : ptt_pkg::S_PAN_START;
                end
            end
            ptt_pkg::S_SEARCH:     n_state = ptt_pkg::S_FINISH;
            ptt_pkg::S_PAN_START:  n_state = ptt_pkg::S_PAN_WAIT;
            ptt_pkg::S_PAN_WAIT: begin
                if (w_rsp.done) begin
                    n_state = ptt_pkg::S_TILT_START;
                end
            end
            ptt_pkg::S_TILT_START: n_state = ptt_pkg::S_TILT_WAIT;
            ptt_pkg::S_TILT_WAIT: begin
                if (w_rsp.done) begin
                    n_state = ptt_pkg::S_FINISH;
                end
            end
            ptt_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = ptt_pkg::S_IDLE;
                end
            end
            default: n_state = ptt_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_req.start    = (r_state == ptt_pkg::S_PAN_START) ||
                         (r_state == ptt_pkg::S_TILT_START);
        w_req.dividend = w_mag;
        w_req.divisor  = (w_gain == '0) ? W'(1) : w_gain;
        o_stall        = (r_state != ptt_pkg::S_IDLE) || !i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_target  <= 8'd80;
            r_tilt_target <= 8'd120;
            r_pan_band    <= 8'd6;
            r_tilt_band   <= 8'd6;
            r_pan_div     <= 8'd8;
            r_tilt_div    <= 8'd8;
            r_tilt_min    <= 8'd0;
            r_tilt_max    <= 8'd255;
        end else if (i_cfg_we) begin
            unique case (ptt_pkg::t_cfg_idx'(i_cfg_idx))
                ptt_pkg::CFG_PAN_TARGET:  r_pan_target  <= i_cfg_data;
                ptt_pkg::CFG_TILT_TARGET: r_tilt_target <= i_cfg_data;
                ptt_pkg::CFG_PAN_BAND:    r_pan_band    <= i_cfg_data;
                ptt_pkg::CFG_TILT_BAND:   r_tilt_band   <= i_cfg_data;
                ptt_pkg::CFG_PAN_DIV:     r_pan_div     <= i_cfg_data;
                ptt_pkg::CFG_TILT_DIV:    r_tilt_div    <= i_cfg_data;
                ptt_pkg::CFG_TILT_MIN:    r_tilt_min    <= i_cfg_data;
                ptt_pkg::CFG_TILT_MAX:    r_tilt_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tracker state and packet bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan   <= ptt_pkg::DRIVE_STOP;
            r_tilt  <= 8'd127;
            r_wait  <= '0;
            r_fresh <= 1'b1;
        end else begin
            unique case (r_state)
                ptt_pkg::S_SEARCH: begin
                    if (w_search_step) begin
                        r_pan <= ptt_pkg::DRIVE_STOP;
                        if (r_fresh) begin
                            r_fresh <= 1'b0;
                            r_wait  <= '0;
                            r_tilt  <= TILT_CENTER;
                        end else begin
                            r_wait <= ptt_pkg::WAIT_W'(1);
                            r_tilt <= w_sweep_tilt;
                        end
                    end else begin
                        r_wait <= w_cnt[ptt_pkg::WAIT_W-1:0];
                    end
                end
                ptt_pkg::S_PAN_START: r_fresh <= 1'b1;
                ptt_pkg::S_PAN_WAIT: begin
                    if (w_rsp.done) begin
                        r_pan <= w_pan_sat;
                    end
                end
                ptt_pkg::S_TILT_WAIT: begin
                    if (w_rsp.done) begin
                        r_tilt <= w_tilt_clamp;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tx <= i_target_x;
            r_ty <= i_target_y;
        end
        if (w_req.start) begin
            r_outside <= w_mag > w_band;
            r_neg     <= w_err[W];
        end
        if (r_state == ptt_pkg::S_SEARCH) begin
            r_upd    <= w_search_step;
            r_status <= ptt_pkg::STATUS_SEARCH;
        end
        if (r_state == ptt_pkg::S_PAN_START) begin
            r_upd    <= 1'b1;
            r_status <= (w_mag > w_band) ? ptt_pkg::STATUS_OFF_CENTER : ptt_pkg::STATUS_AIMED;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_pan    <= r_pan;
            r_o_tilt   <= r_tilt;
            r_o_upd    <= r_upd;
            r_o_status <= r_status;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pan_drive     = r_o_pan;
    assign o_tilt_position = r_o_tilt;
    assign o_drive_updated = r_o_upd;
    assign o_status        = r_o_status;

endmodule

// File: rtl/core/ptt_div.sv
// ptt_div: restoring serial divider, one quotient bit per cycle
// depends on ptt_pkg for the request and response structs
module ptt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptt_pkg::t_div_req i_req,
    output ptt_pkg::t_div_rsp o_rsp
);

    localparam int W   = ptt_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;

    logic [W:0]   w_trial;
    logic         w_fits;
    logic [W-1:0] n_rem;

    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_fits  = w_trial >= {1'b0, r_den};
    assign n_rem   = w_fits ? W'(w_trial - {1'b0, r_den}) : w_trial[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[W-2:0], w_fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/core/ptt_checker.sv
// ptt_checker: port-level assertions on the tracker result channel
// depends on ptt_pkg; bound to pan_tilt_target_tracker below
module ptt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_pan_drive,
    input logic [7:0] o_tilt_position,
    input logic       o_drive_updated,
    input logic [1:0] o_status
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pan_drive) &&
        $stable(o_tilt_position) && $stable(o_drive_updated) && $stable(o_status))
        else $error("stalled result beat changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // locked packets always write the drives
    a_lock_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ptt_pkg::STATUS_OFF_CENTER ||
                    o_status == ptt_pkg::STATUS_AIMED) |-> o_drive_updated)
        else $error("locked beat without update");

    a_aimed_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ptt_pkg::STATUS_AIMED |-> o_pan_drive == ptt_pkg::DRIVE_STOP)
        else $error("pan moving while aimed");

    a_search_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ptt_pkg::STATUS_SEARCH && o_drive_updated |->
        o_pan_drive == ptt_pkg::DRIVE_STOP)
        else $error("pan moving on search step");

endmodule

bind pan_tilt_target_tracker ptt_checker u_ptt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pan_drive     (o_pan_drive),
    .o_tilt_position (o_tilt_position),
    .o_drive_updated (o_drive_updated),
    .o_status        (o_status)
);
